@@ src/ptd_pkg.sv @@
// shared types and constants of the periodic task dispatcher
package ptd_pkg;

	localparam int MAX_SLOTS = 5;
	localparam int RELOAD_W = 24;
	localparam int QUOT_W = 10;
	localparam int DIVIDEND_W = RELOAD_W + QUOT_W;

	// item kinds
	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_FAST = 2'd1;
	localparam logic [1:0] KIND_PASS = 2'd2;

	// register indexes
	localparam logic [2:0] REG_RELOAD = 3'd5;

	localparam logic [9:0] US_PER_MS = 10'd1000;
	localparam logic [7:0] FAST_MAX = 8'd255;
	localparam logic [RELOAD_W-1:0] RELOAD_RESET = 24'd169999;
	localparam logic [31:0] PERIOD_RESET [MAX_SLOTS] = '{
		32'd2000, 32'd6000, 32'd11000, 32'd20000, 32'd50000
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [23:0] timer_value;
	} item_t;

	typedef struct packed {
		logic [2:0] task_id;
		logic [31:0] elapsed_us;
		logic last;
	} result_t;

	typedef struct packed {
		logic start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [RELOAD_W-1:0] divisor;
	} div_req_t;

endpackage

@@ src/ptd_div.sv @@
// restoring divider, one quotient bit per cycle
module ptd_div (
	input logic clk,
	input logic arst_n,
	input ptd_pkg::div_req_t req,
	output logic done,
	output logic [ptd_pkg::QUOT_W-1:0] quotient
);

	localparam int RW = ptd_pkg::RELOAD_W;
	localparam int QW = ptd_pkg::QUOT_W;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] rem_q;
	logic [QW-1:0] dq_q;
	logic [RW-1:0] divisor_q;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [RW:0] shifted;
	logic [RW+1:0] trial;

	// quotient stays below 2^QW, so the top bits start below the divisor
	assign shifted = {rem_q, dq_q[QW-1]};
	assign trial = {1'b0, shifted} - {2'b00, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q <= req.dividend[ptd_pkg::DIVIDEND_W-1:QW];
				dq_q <= req.dividend[QW-1:0];
				divisor_q <= req.divisor;
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				if (!trial[RW+1]) begin
					rem_q <= trial[RW-1:0];
					dq_q <= {dq_q[QW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[RW-1:0];
					dq_q <= {dq_q[QW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

endmodule

@@ src/periodic_task_dispatcher_core.sv @@
// top level of the periodic task dispatcher
//
// channel   direction  handshake                     payload
// item      in         start & !busy                 item (kind, timer_value)
// result    out        result_valid, one cycle each  result (task_id, elapsed_us, last)
// config    in         cfg_valid & cfg_ready         cfg_index, cfg_data
//
// tick, fast interrupt and unknown kinds finish in the accepting cycle
// a pass runs through one multiply, a divider load, ten divider
// steps for the fractional millisecond, a wait for done, one sum, one compare
// per slot, one flush
// results leave one per cycle and cannot be held off; the last one may show
// in the cycle the block is ready again
// reset clears counters, last-run times and restores periods and reload
module periodic_task_dispatcher_core #(
	parameter int SLOTS = 5
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ptd_pkg::item_t item,
	output logic result_valid,
	output ptd_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = ptd_pkg::RELOAD_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_DIVGO,
		S_DIV,
		S_SUM,
		S_SLOT,
		S_FLUSH
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] period_q [SLOTS];
	logic [RW-1:0] reload_q;

	// timekeeping state
	logic [31:0] ms_q;
	logic [7:0] fast_q;
	logic [31:0] lrt_q [SLOTS];

	// pass working registers
	logic [RW-1:0] diff_q;
	logic [ptd_pkg::DIVIDEND_W-1:0] prod_q;
	logic [31:0] ms_us_q;
	logic [31:0] now_q;
	logic [SLOT_W-1:0] slot_q;

	// one result held back so the final one can carry last
	logic pend_vld_q;
	logic [2:0] pend_id_q;
	logic [31:0] pend_el_q;

	ptd_pkg::result_t res_q;
	logic res_vld_q;

	ptd_pkg::div_req_t div_req;
	logic div_done;
	logic [ptd_pkg::QUOT_W-1:0] div_quot;

	logic accept;
	logic cfg_wr;
	logic [RW-1:0] tv_clamped;
	logic [31:0] elapsed;
	logic due;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept = start && !busy;
	assign cfg_wr = cfg_valid && cfg_ready;

	// counter above reload is clamped
	assign tv_clamped = (item.timer_value > reload_q) ? reload_q : item.timer_value;

	// shared subtract and compare, one slot per cycle
	assign elapsed = now_q - lrt_q[slot_q];
	assign due = (elapsed >= period_q[slot_q]);

	assign div_req.start = (state_q == S_DIVGO);
	assign div_req.dividend = prod_q;
	assign div_req.divisor = reload_q;

	ptd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= ptd_pkg::PERIOD_RESET[i];
				lrt_q[i] <= '0;
			end
			reload_q <= ptd_pkg::RELOAD_RESET;
			ms_q <= '0;
			fast_q <= '0;
			slot_q <= '0;
			pend_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
			res_q <= '0;
		end else begin
			res_vld_q <= 1'b0;

			if (cfg_wr) begin
				if (cfg_index < 3'(SLOTS)) begin
					period_q[cfg_index[SLOT_W-1:0]] <= cfg_data;
				end else if (cfg_index == ptd_pkg::REG_RELOAD) begin
					reload_q <= cfg_data[RW-1:0];
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.kind)
							ptd_pkg::KIND_TICK: ms_q <= ms_q + 32'd1;
							ptd_pkg::KIND_FAST: begin
								if (fast_q != ptd_pkg::FAST_MAX) begin
									fast_q <= fast_q + 8'd1;
								end
							end
							ptd_pkg::KIND_PASS: begin
								diff_q <= reload_q - tv_clamped;
								// fast event goes first
								if (fast_q != '0) begin
									fast_q <= fast_q - 8'd1;
									pend_vld_q <= 1'b1;
									pend_id_q <= '0;
									pend_el_q <= '0;
								end
								state_q <= S_PROD;
							end
							default: ;
						endcase
					end
				end
				S_PROD: begin
					prod_q <= ptd_pkg::DIVIDEND_W'(diff_q) *
						ptd_pkg::DIVIDEND_W'(ptd_pkg::US_PER_MS);
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					ms_us_q <= ms_q * 32'(ptd_pkg::US_PER_MS);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// zero reload gives no fractional part
					now_q <= (reload_q == '0) ? ms_us_q : ms_us_q + 32'(div_quot);
					slot_q <= '0;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (due) begin
						lrt_q[slot_q] <= now_q;
						if (pend_vld_q) begin
							res_vld_q <= 1'b1;
							res_q <= '{task_id: pend_id_q, elapsed_us: pend_el_q, last: 1'b0};
						end
						pend_vld_q <= 1'b1;
						pend_id_q <= 3'(slot_q) + 3'd1;
						pend_el_q <= elapsed;
					end
					if (slot_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= S_FLUSH;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_FLUSH: begin
					if (pend_vld_q) begin
						res_vld_q <= 1'b1;
						res_q <= '{task_id: pend_id_q, elapsed_us: pend_el_q, last: 1'b1};
					end
					pend_vld_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

endmodule

@@ src/ptd_checker.sv @@
// port-level checks of the periodic task dispatcher
module ptd_port_checks (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input ptd_pkg::item_t item,
	input logic result_valid,
	input ptd_pkg::result_t result
);

	// a finished pass leaves a quiet cycle behind its last result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result right after last");

	// ticks and interrupts finish at once
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind != ptd_pkg::KIND_PASS |=> !busy && !result_valid)
		else $error("non-pass item kept the block busy");

	// a pass occupies the block
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.kind == ptd_pkg::KIND_PASS |=> busy)
		else $error("pass not started");

	// fast task carries no elapsed time
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.task_id == 3'd0 |-> result.elapsed_us == 32'd0)
		else $error("fast task with elapsed time");

	// no result outside a pass or its flush
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy |-> result.last)
		else $error("result while idle");

endmodule

bind periodic_task_dispatcher_core ptd_port_checks u_ptd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.item         (item),
	.result_valid (result_valid),
	.result       (result)
);

@@ tb/ptd_checker.sv @@
`timescale 1ns / 1ps
// dispatch checker: predicts task dispatches from observed items and compares results
module ptd_checker
	import ptd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input item_t item,
	input logic result_valid,
	input result_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output int mismatches,
	output int outstanding
);

	localparam logic [2:0] FAST_TASK = 3'd0;

	logic [31:0] period [MAX_SLOTS];
	logic [RELOAD_W-1:0] reload;
	logic [31:0] ms_count;
	logic [7:0] fast_pending;
	logic [31:0] slot_stamp [MAX_SLOTS];
	result_t dispatch_q [$];

	// microsecond time from the millisecond count and the down-counter
	function automatic logic [31:0] sample_us(input logic [RELOAD_W-1:0] tv);
		logic [RELOAD_W-1:0] v;
		logic [63:0] span;
		logic [63:0] divisor;
		logic [63:0] frac;
		logic [31:0] now;
		v = (tv > reload) ? reload : tv;
		span = 64'(reload) - 64'(v);
		divisor = 64'(reload);
		frac = 64'd0;
		if (reload != '0)
			frac = (span * 64'(US_PER_MS)) / divisor;
		now = ms_count * 32'(US_PER_MS) + frac[31:0];
		return now;
	endfunction

	task automatic predict_dispatch(input item_t it);
		result_t due [MAX_SLOTS+1];
		result_t r;
		logic [31:0] now;
		logic [31:0] gap;
		int n;
		int i;
		n = 0;
		case (it.kind)
		KIND_TICK: begin
			ms_count = ms_count + 32'd1;
		end
		KIND_FAST: begin
			if (fast_pending != FAST_MAX)
				fast_pending = fast_pending + 8'd1;
		end
		KIND_PASS: begin
			if (fast_pending != 8'd0) begin
				fast_pending = fast_pending - 8'd1;
				due[n] = '{task_id: FAST_TASK, elapsed_us: 32'd0, last: 1'b0};
				n++;
			end
			now = sample_us(it.timer_value);
			for (i = 0; i < MAX_SLOTS; i++) begin
				gap = now - slot_stamp[i];
				if (gap >= period[i]) begin
					slot_stamp[i] = now;
					due[n] = '{task_id: 3'(i + 1), elapsed_us: gap, last: 1'b0};
					n++;
				end
			end
			for (i = 0; i < n; i++) begin
				r = due[i];
				r.last = (i == n - 1);
				dispatch_q.push_back(r);
			end
		end
		default: begin
		end
		endcase
	endtask

	task automatic check_dispatch(input result_t got);
		result_t want;
		if (dispatch_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result task %0d elapsed %0d last %0b",
					$time, got.task_id, got.elapsed_us, got.last);
		end else begin
			want = dispatch_q.pop_front();
			if (got.task_id !== want.task_id || got.elapsed_us !== want.elapsed_us ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected task %0d elapsed %0d last %0b,",
						$time, want.task_id, want.elapsed_us, want.last,
						" got task %0d elapsed %0d last %0b",
						got.task_id, got.elapsed_us, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				period[s] = PERIOD_RESET[s];
				slot_stamp[s] = 32'd0;
			end
			reload = RELOAD_RESET;
			ms_count = 32'd0;
			fast_pending = 8'd0;
			dispatch_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// results first: an item accepted in the same cycle only adds behind them
			if (result_valid)
				check_dispatch(result);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < REG_RELOAD)
					period[cfg_index] = cfg_data;
				else if (cfg_index == REG_RELOAD)
					reload = cfg_data[RELOAD_W-1:0];
			end
			if (start && !busy)
				predict_dispatch(item);
			outstanding = dispatch_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, item and register stimulus, final verdict
module tb;
	import ptd_pkg::*;

	// kind value the block must ignore
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// period registers sit at the bottom of the register map
	localparam logic [2:0] REG_PERIOD0 = 3'd0;
	// first index past the register map, writes there are dropped
	localparam logic [2:0] REG_SPARE = 3'd6;
	// settle time after draining, with a margin over a whole pass
	localparam int SETTLE = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic result_valid;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	int mismatches;
	int outstanding;

	// stimulus side copy of the reload, only used to shape timer values
	logic [RELOAD_W-1:0] cur_reload;
	// set during stretches that must run without any idle cycles
	bit quiet;

	always #4 clk = ~clk;

	periodic_task_dispatcher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ptd_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// present one item at the falling edge and hold it until the block takes it
	// start stays high afterwards so back-to-back items need no extra cycle
	task automatic send(input logic [1:0] kind, input logic [RELOAD_W-1:0] tv);
		if (!quiet && $urandom_range(99) < 8) begin
			start = 1'b0;
			// gap lengths up to a whole pass so idles land on every phase of it
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
		start = 1'b1;
		item.kind = kind;
		item.timer_value = tv;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// register write on its own channel, only ever taken while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		if (!quiet && $urandom_range(99) < 8)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_RELOAD)
			cur_reload = data[RELOAD_W-1:0];
	endtask

	// wait until every expected dispatch came out, then let a silent pass finish
	task automatic drain();
		start = 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// random item mix: mostly ticks and passes so slots keep coming due
	task automatic send_random(input int count);
		int k;
		int pick;
		logic [1:0] kind;
		logic [RELOAD_W-1:0] tv;
		for (k = 0; k < count; k++) begin
			pick = int'($urandom_range(99));
			if (pick < 40)
				kind = KIND_TICK;
			else if (pick < 55)
				kind = KIND_FAST;
			else if (pick < 95)
				kind = KIND_PASS;
			else
				kind = KIND_UNUSED;
			// timer value: clamp boundaries, full-range noise, or in-range counts
			pick = int'($urandom_range(99));
			if (pick < 10)
				tv = '0;
			else if (pick < 20)
				tv = cur_reload;
			else if (pick < 30)
				tv = '1;
			else if (pick < 60)
				tv = RELOAD_W'($urandom);
			else
				tv = RELOAD_W'($urandom_range(0, cur_reload));
			send(kind, tv);
		end
	endtask

	initial begin
		int s;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_reload = RELOAD_RESET;
		quiet = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part under reset settings
		// pass at time zero: fractional term zero, nothing due yet
		send(KIND_PASS, RELOAD_RESET);
		// counter above reload gets clamped, still nothing due
		send(KIND_PASS, 24'hFFFFFF);
		// counter at zero gives the largest fraction of a millisecond
		send(KIND_PASS, 24'd0);
		send(KIND_FAST, 24'd0);
		send(KIND_FAST, 24'hFFFFFF);
		// unused kind must leave the state alone
		send(KIND_UNUSED, 24'hA5A5A5);
		// two passes drain both fast events, the third emits nothing
		send(KIND_PASS, 24'd85000);
		send(KIND_PASS, 24'd1);
		send(KIND_PASS, 24'd1);
		repeat (3) send(KIND_TICK, 24'h5A5A5A);
		// first periodic slot comes due alone
		send(KIND_PASS, 24'd0);
		repeat (6) send(KIND_TICK, 24'd0);
		// two slots together, then fast task ahead of periodic ones
		send(KIND_PASS, RELOAD_RESET / 2);
		send(KIND_FAST, 24'd0);
		repeat (3) send(KIND_TICK, 24'd0);
		send(KIND_PASS, 24'd1234);
		drain();

		// short periods and a small reload: frequent dispatches
		for (s = 0; s < MAX_SLOTS; s++)
			write_reg(REG_PERIOD0 + 3'(s), $urandom_range(0, 3000));
		write_reg(REG_RELOAD, $urandom_range(1, 1000));
		send_random(10);
		drain();

		// zero periods make every slot due on every pass, largest reload,
		// run without any idle cycles
		quiet = 1'b1;
		for (s = 0; s < MAX_SLOTS; s++)
			write_reg(REG_PERIOD0 + 3'(s), 32'd0);
		// upper data bits beyond the reload width are dropped
		write_reg(REG_RELOAD, 32'hFFFFFFFF);
		send_random(8);
		drain();
		quiet = 1'b0;

		// largest periods never come due, zero reload drops the fraction,
		// writes past the register map are ignored
		for (s = 0; s < MAX_SLOTS; s++)
			write_reg(REG_PERIOD0 + 3'(s), (s % 2 == 0) ? 32'hFFFFFFFF :
				$urandom_range(500, 20000));
		write_reg(REG_RELOAD, 32'd0);
		write_reg(REG_SPARE, $urandom);
		write_reg(REG_SPARE + 3'd1, $urandom);
		send_random(10);
		drain();

		// smallest reload, one period with random bits everywhere
		write_reg(REG_PERIOD0, $urandom);
		for (s = 1; s < MAX_SLOTS; s++)
			write_reg(REG_PERIOD0 + 3'(s), $urandom_range(1000, 60000));
		write_reg(REG_RELOAD, {8'($urandom), 24'd1});
		send_random(10);

		// fast pending count saturates, then passes keep emitting the fast task
		quiet = 1'b1;
		repeat (256) send(KIND_FAST, RELOAD_W'($urandom));
		quiet = 1'b0;
		repeat (3) send(KIND_PASS, RELOAD_W'($urandom));

		start = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
src/ptd_pkg.sv
src/ptd_div.sv
src/periodic_task_dispatcher_core.sv
src/ptd_checker.sv
tb/ptd_checker.sv
tb/tb.sv
